>>> hw/rtl/bdy_pkg.sv
// Shared types and constants for the buddy allocator.
// No dependencies; imported by buddy_allocator_with_fit_modes.
`default_nettype none

package bdy_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int MIN_ORDER_DEF = 5;

    localparam int ORD_W    = 5;
    localparam int TAG_W    = 7;
    localparam int REQ_W    = 17;
    localparam int NEED_W   = 18;
    localparam int OFF_W    = 16;
    localparam int CFG_DW   = 5;
    localparam int CFG_IW   = 1;

    localparam logic [REQ_W-1:0] MIN_REQUEST  = 17'd16;
    localparam logic [NEED_W-1:0] HEADER_BYTES = 18'd1;

    localparam logic [ORD_W-1:0] POOL_ORDER_RST = 5'd16;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_POOL_ORDER = 1'b0;
    localparam logic [CFG_IW-1:0] REG_FIT_MODE   = 1'b1;

    // fit modes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  free_offset;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]  alloc_offset;
        logic [ORD_W-1:0]  block_order;
        logic [1:0]        status;
    } t_out_item;

    // tag: start, used, order
    function automatic logic [TAG_W-1:0] f_tag_free(input logic [ORD_W-1:0] o);
        f_tag_free = {1'b1, 1'b0, o};
    endfunction

    function automatic logic [TAG_W-1:0] f_tag_used(input logic [ORD_W-1:0] o);
        f_tag_used = {1'b1, 1'b1, o};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/buddy_allocator_with_fit_modes.sv
// Buddy allocator with first/best/worst fit over a granule tag memory.
// Allocate walks block starts, reading then checking each tag, then splits the
//   block one halving at a time; free checks the tag, reads and checks the buddy
//   per merge, then posts. One item is handled at a time; the tag RAM walk dominates.
// Reset (sync, i_rst_n low) and every pool_order write start a clearing pass
//   over all 2^(MAX_ORDER-MIN_ORDER) tag entries (2048 by default); no item is taken then.
`default_nettype none

module buddy_allocator_with_fit_modes #(
    parameter int MAX_ORDER = bdy_pkg::MAX_ORDER_DEF,
    parameter int MIN_ORDER = bdy_pkg::MIN_ORDER_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire bdy_pkg::t_in_item         i_in_item,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output bdy_pkg::t_out_item             o_out_item,
    // configuration writes
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bdy_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [bdy_pkg::CFG_DW-1:0] i_cfg_data
);

    import bdy_pkg::*;

    // granule index width and helpers
    localparam int GW = MAX_ORDER - MIN_ORDER;
    localparam int CW = GW + 1;
    localparam int NW = (MAX_ORDER + 1 > NEED_W) ? MAX_ORDER + 1 : NEED_W;
    localparam int SW = (MAX_ORDER > OFF_W) ? MAX_ORDER : OFF_W;
    localparam logic [ORD_W-1:0] MIN_O = ORD_W'(MIN_ORDER);
    localparam logic [ORD_W-1:0] MAX_O = ORD_W'(MAX_ORDER);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT,
        S_F_CHK, S_M_RD, S_M_CHK, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [GW-1:0]       r_clr, n_clr;
    logic [CW-1:0]       r_g, n_g;
    logic [GW-1:0]       r_best, n_best;
    logic [ORD_W-1:0]    r_best_o, n_best_o;
    logic                r_found, n_found;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [ORD_W-1:0]    r_o, n_o;
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;
    logic [ORD_W-1:0]    r_pool_order;
    logic [1:0]          r_fit;

    // tag RAM port
    logic                w_we;
    logic [GW-1:0]       w_waddr;
    logic [TAG_W-1:0]    w_wdata;
    logic [GW-1:0]       w_raddr;
    logic [TAG_W-1:0]    w_rdata;

    logic [ORD_W-1:0]    w_eff;
    logic [CW-1:0]       w_pgran;
    logic [SW-1:0]       w_start;
    logic                w_free_bad;
    logic [REQ_W-1:0]    w_req;
    logic [ORD_W-1:0]    w_to;
    logic                w_take;
    logic [CW-1:0]       w_step;
    logic [CW-1:0]       w_gnx;
    logic [ORD_W-1:0]    w_nbo;
    logic [GW-1:0]       w_bg;
    logic [SW-1:0]       w_aoff;
    logic                w_first;
    logic                w_cfg_wr;

    // block of order o holds need bytes
    function automatic logic f_fits(input logic [ORD_W-1:0] o,
                                    input logic [NEED_W-1:0] need);
        f_fits = (o <= MAX_O) && ((NW'(1) << o) >= NW'(need));
    endfunction

    bdy_tag_ram #(.AW(GW), .DW(TAG_W)) u_tags (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // pool order clamped to the supported range
    always_comb begin
        if (r_pool_order < MIN_O) begin
            w_eff = MIN_O;
        end else if (r_pool_order > MAX_O) begin
            w_eff = MAX_O;
        end else begin
            w_eff = r_pool_order;
        end
    end

    assign w_pgran = CW'(1) << (w_eff - MIN_O);
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    // free address check on the incoming item
    assign w_start    = SW'(i_in_item.free_offset) - SW'(1);
    assign w_free_bad = (i_in_item.free_offset == '0) || ((w_start >> w_eff) != '0)
                        || (w_start[MIN_ORDER-1:0] != '0);
    assign w_req      = (i_in_item.request_bytes < MIN_REQUEST) ? MIN_REQUEST
                                                                : i_in_item.request_bytes;

    // scan decision on the tag just read
    assign w_to    = w_rdata[ORD_W-1:0];
    assign w_first = (r_fit != FIT_BEST) && (r_fit != FIT_WORST);
    assign w_take  = (w_rdata[TAG_W-1:TAG_W-2] == 2'b10) && f_fits(w_to, r_need)
                     && (!r_found || (r_fit == FIT_BEST && w_to < r_best_o)
                                  || (r_fit == FIT_WORST && w_to > r_best_o));
    // hop to the next block start; fall back to one granule on an odd tag
    assign w_step  = (w_rdata[TAG_W-1] && w_to >= MIN_O && w_to <= MAX_O)
                     ? (CW'(1) << (w_to - MIN_O)) : CW'(1);
    assign w_gnx   = r_g + w_step;

    assign w_nbo  = r_best_o - ORD_W'(1);
    assign w_bg   = r_g[GW-1:0] ^ (GW'(1) << (r_o - MIN_O));
    assign w_aoff = SW'({r_best, {MIN_ORDER{1'b0}}}) | SW'(1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_g         = r_g;
        n_best      = r_best;
        n_best_o    = r_best_o;
        n_found     = r_found;
        n_need      = r_need;
        n_o         = r_o;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_g[GW-1:0];
        w_wdata     = f_tag_free(r_o);
        w_raddr     = r_g[GW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = (r_clr == '0) ? f_tag_free(w_eff) : '0;
                n_clr   = r_clr + GW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_raddr = w_start[MIN_ORDER +: GW];
                if (i_in_valid) begin
                    if (i_in_item.op == OP_ALLOC) begin
                        n_need  = NEED_W'(w_req) + HEADER_BYTES;
                        n_g     = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN_RD;
                    end else if (w_free_bad) begin
                        n_res   = '{alloc_offset: '0, block_order: '0, status: ST_BAD_FREE};
                        n_state = S_DONE;
                    end else begin
                        n_g     = CW'(w_start[MIN_ORDER +: GW]);
                        n_state = S_F_CHK;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (w_take) begin
                    n_best   = r_g[GW-1:0];
                    n_best_o = w_to;
                    n_found  = 1'b1;
                end
                if (w_take && w_first) begin
                    n_state = S_SPLIT;
                end else if (w_gnx >= w_pgran) begin
                    if (r_found || w_take) begin
                        n_state = S_SPLIT;
                    end else begin
                        n_res   = '{alloc_offset: '0, block_order: '0, status: ST_NO_BLOCK};
                        n_state = S_DONE;
                    end
                end else begin
                    n_g     = w_gnx;
                    n_state = S_SCAN_RD;
                end
            end
            S_SPLIT: begin
                w_we = 1'b1;
                if (r_best_o > MIN_O && f_fits(w_nbo, r_need)) begin
                    // upper half becomes a free block
                    w_waddr  = r_best + (GW'(1) << (w_nbo - MIN_O));
                    w_wdata  = f_tag_free(w_nbo);
                    n_best_o = w_nbo;
                end else begin
                    w_waddr = r_best;
                    w_wdata = f_tag_used(r_best_o);
                    n_res   = '{alloc_offset: w_aoff[OFF_W-1:0], block_order: r_best_o,
                                status: ST_OK};
                    n_state = S_DONE;
                end
            end
            S_F_CHK: begin
                if (w_rdata[TAG_W-1:TAG_W-2] == 2'b11 && w_to >= MIN_O && w_to <= w_eff) begin
                    n_o     = w_to;
                    n_state = S_M_RD;
                end else begin
                    n_res   = '{alloc_offset: '0, block_order: '0, status: ST_BAD_FREE};
                    n_state = S_DONE;
                end
            end
            S_M_RD: begin
                if (r_o < w_eff) begin
                    w_raddr = w_bg;
                    n_state = S_M_CHK;
                end else begin
                    w_we    = 1'b1;
                    n_res   = '{alloc_offset: '0, block_order: r_o, status: ST_OK};
                    n_state = S_DONE;
                end
            end
            S_M_CHK: begin
                w_we = 1'b1;
                if (w_rdata == f_tag_free(r_o)) begin
                    // merge: drop the upper start tag
                    w_wdata = '0;
                    if (w_bg > r_g[GW-1:0]) begin
                        w_waddr = w_bg;
                    end else begin
                        n_g = CW'(w_bg);
                    end
                    n_o     = r_o + ORD_W'(1);
                    n_state = S_M_RD;
                end else begin
                    n_res   = '{alloc_offset: '0, block_order: r_o, status: ST_OK};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // pool resize restarts the clearing pass
        if (w_cfg_wr && i_cfg_index == REG_POOL_ORDER) begin
            n_state = S_CLEAR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_pool_order <= POOL_ORDER_RST;
            r_fit        <= FIT_FIRST;
            r_found      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            if (w_cfg_wr) begin
                if (i_cfg_index == REG_POOL_ORDER) begin
                    r_pool_order <= i_cfg_data;
                end else begin
                    r_fit <= i_cfg_data[1:0];
                end
            end
        end
        r_g      <= n_g;
        r_best   <= n_best;
        r_best_o <= n_best_o;
        r_need   <= n_need;
        r_o      <= n_o;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // errors carry no offset and no order
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK)
        |-> (o_out_item.alloc_offset == '0 && o_out_item.block_order == '0))
        else $error("error result with nonzero payload");

    // good results name a block order inside the pool
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_OK)
        |-> (o_out_item.block_order >= MIN_O && o_out_item.block_order <= w_eff))
        else $error("block order out of range");

    // tag RAM is quiet while waiting for an item
    a_idle_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("tag write while idle");

    // scan data always follows its read cycle
    a_scan_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> ($past(r_state) == S_SCAN_RD))
        else $error("scan check without read");

endmodule

`default_nettype wire

>>> hw/rtl/bdy_tag_ram.sv
// Granule tag memory: one write port, one read port, registered read data.
// No package dependency.
`default_nettype none

module bdy_tag_ram #(
    parameter int AW = 11,
    parameter int DW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
